// ===== src/dprl_pkg.sv =====
// shared constants and types of the descending prime range lister
// no dependencies; used by dprl_divider and the top level
package dprl_pkg;

  localparam int NUM_WIDTH      = 16;
  localparam int MAX_SPAN       = 256;
  localparam int MAX_RESULTS    = 54;
  localparam int SMALLEST_PRIME = 2;

  localparam int SQ_W   = NUM_WIDTH + 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int STEP_W = $clog2(NUM_WIDTH + 1);

  typedef struct packed {
    logic                 start;
    logic [NUM_WIDTH-1:0] dividend;
    logic [NUM_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [NUM_WIDTH-1:0] rem;
  } div_rsp_t;

endpackage

// ===== src/descending_prime_range_lister_top.sv =====
// top level of the descending prime range lister: sequencer, window setup,
// trial division loop and result register; uses dprl_pkg and dprl_divider
//
//   channel   | signals                                   | handshake
//   ----------+-------------------------------------------+------------------------
//   range in  | range_low_i, range_high_i                 | start, taken when !busy
//   prime out | prime_value_o, last_o, truncated_o        | result_valid_o, 1 cycle
//
// busy stays high while a range transaction runs, until its last prime
// has been placed in the output register. each candidate n is tested with
// trial divisors d from 2 while d*d <= n, all on the one serial divider.
// reset clears the sequencer and drops any strobe. the receiver cannot
// stall, so each result is shown for exactly one cycle.
module descending_prime_range_lister_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [dprl_pkg::NUM_WIDTH-1:0] range_low_i,
  input  logic [dprl_pkg::NUM_WIDTH-1:0] range_high_i,
  output logic                           result_valid_o,
  output logic [dprl_pkg::NUM_WIDTH-1:0] prime_value_o,
  output logic                           last_o,
  output logic                           truncated_o
);
  import dprl_pkg::*;

  // sequencer state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2; // new candidate
  localparam logic [2:0] ST_CHECK = 3'd3; // d*d > n test, launch divide
  localparam logic [2:0] ST_WAIT  = 3'd4; // divider running
  localparam logic [2:0] ST_PRIME = 3'd5; // candidate found prime
  localparam logic [2:0] ST_NEXT  = 3'd6; // step down the window
  localparam logic [2:0] ST_FLUSH = 3'd7; // emit held prime as last

  logic [2:0] state_q, state_d;

  // window and candidate
  logic [NUM_WIDTH-1:0] lo_q, lo_d;
  logic [NUM_WIDTH-1:0] hi_q, hi_d;
  logic [NUM_WIDTH-1:0] cur_q, cur_d;
  logic                 trunc_q, trunc_d;

  // trial divisor and its square
  logic [NUM_WIDTH-1:0] div_q, div_d;
  logic [SQ_W-1:0]      sq_q, sq_d;

  // one prime is held back until we know whether another follows
  logic                 hold_vld_q, hold_vld_d;
  logic [NUM_WIDTH-1:0] hold_q, hold_d;
  logic [CNT_W-1:0]     found_q, found_d;

  // output register
  logic                 out_vld_q, out_vld_d;
  logic [NUM_WIDTH-1:0] out_val_q, out_val_d;
  logic                 out_last_q, out_last_d;
  logic                 out_trunc_q, out_trunc_d;

  logic [NUM_WIDTH-1:0] span;
  logic [31:0]          span_ext;

  div_req_t div_req;
  div_rsp_t div_rsp;

  dprl_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign span     = hi_q - lo_q;
  assign span_ext = 32'(span);

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cur_d       = cur_q;
    trunc_d     = trunc_q;
    div_d       = div_q;
    sq_d        = sq_q;
    hold_vld_d  = hold_vld_q;
    hold_d      = hold_q;
    found_d     = found_q;
    out_vld_d   = 1'b0;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_trunc_d = out_trunc_q;
    div_req.start    = 1'b0;
    div_req.dividend = cur_q;
    div_req.divisor  = div_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          lo_d    = range_low_i;
          hi_d    = range_high_i;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        hold_vld_d = 1'b0;
        found_d    = '0;
        trunc_d    = 1'b0;
        cur_d      = hi_q;
        if (lo_q > hi_q) begin
          // inverted range gives nothing
          state_d = ST_IDLE;
        end else begin
          if (span_ext >= 32'(MAX_SPAN)) begin
            // keep only the top MAX_SPAN values
            lo_d    = hi_q - NUM_WIDTH'(MAX_SPAN - 1);
            trunc_d = 1'b1;
          end
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        div_d = NUM_WIDTH'(SMALLEST_PRIME);
        sq_d  = SQ_W'(SMALLEST_PRIME * SMALLEST_PRIME);
        if (cur_q < NUM_WIDTH'(SMALLEST_PRIME)) begin
          state_d = ST_NEXT;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_q > {1'b0, cur_q}) begin
          state_d = ST_PRIME;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            state_d = ST_NEXT;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + {div_q, 1'b1};
            div_d   = div_q + NUM_WIDTH'(1);
            state_d = ST_CHECK;
          end
        end
      end
      ST_PRIME: begin
        if (hold_vld_q) begin
          out_vld_d   = 1'b1;
          out_val_d   = hold_q;
          out_last_d  = 1'b0;
          out_trunc_d = trunc_q;
        end
        hold_vld_d = 1'b1;
        hold_d     = cur_q;
        found_d    = found_q + CNT_W'(1);
        if (found_q == CNT_W'(MAX_RESULTS - 1)) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (cur_q == lo_q) begin
          state_d = hold_vld_q ? ST_FLUSH : ST_IDLE;
        end else begin
          cur_d   = cur_q - NUM_WIDTH'(1);
          state_d = ST_INIT;
        end
      end
      ST_FLUSH: begin
        out_vld_d   = 1'b1;
        out_val_d   = hold_q;
        out_last_d  = 1'b1;
        out_trunc_d = trunc_q;
        hold_vld_d  = 1'b0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      hold_vld_q <= 1'b0;
      found_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    cur_q       <= cur_d;
    trunc_q     <= trunc_d;
    div_q       <= div_d;
    sq_q        <= sq_d;
    hold_q      <= hold_d;
    out_val_q   <= out_val_d;
    out_last_q  <= out_last_d;
    out_trunc_q <= out_trunc_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_vld_q;
  assign prime_value_o  = out_val_q;
  assign last_o         = out_last_q;
  assign truncated_o    = out_trunc_q;

  // a strobe always follows a cycle of work on a range transaction
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a running range");

  // every emitted value is at least the smallest prime
  a_value_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (prime_value_o >= NUM_WIDTH'(SMALLEST_PRIME)))
    else $error("emitted value below the smallest prime");

  // the divider only finishes while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_WAIT))
    else $error("divider finished outside the wait state");

  // nothing follows the last prime of a range
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("strobe right after a last result");

endmodule

// ===== src/dprl_divider.sv =====
// serial restoring divider, one remainder bit per cycle
// depends on dprl_pkg for widths and request/response structs
module dprl_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dprl_pkg::div_req_t req_i,
  output dprl_pkg::div_rsp_t rsp_o
);
  import dprl_pkg::*;

  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [NUM_WIDTH-1:0] dvd_q, dvd_d;
  logic [NUM_WIDTH-1:0] dvs_q, dvs_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [NUM_WIDTH:0]   shifted;
  logic [NUM_WIDTH:0]   trial;

  assign shifted = {rem_q, dvd_q[NUM_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      // keep the trial difference when it did not go negative
      rem_d  = trial[NUM_WIDTH] ? shifted[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
      dvd_d  = {dvd_q[NUM_WIDTH-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(NUM_WIDTH - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
